[sv/rism_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rism_pkg;

    // Map geometry
    localparam int MAX_SIDE   = 128;
    localparam int SIDE_W     = $clog2(MAX_SIDE);
    localparam int NUM_LAYERS = 4;
    localparam int LAYER_W    = 2;
    localparam int LAYER_CELLS_W = 2 * SIDE_W;
    localparam int ADDR_W     = LAYER_W + LAYER_CELLS_W;
    localparam int DATA_W     = 32;

    // Shared divider widths
    localparam int DIV_N_W   = 46;
    localparam int DIV_D_W   = 18;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    // Threat of an unknown source: 0.1 in Q12.12
    localparam logic [23:0] UNKNOWN_THREAT = 24'd410;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_SPLAT = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_CELL   = 3'd2,
        CFG_BASE   = 3'd3,
        CFG_GAIN   = 3'd4,
        CFG_SLACK  = 3'd5
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CLR,
        S_QX, S_WX, S_QZ, S_WZ,
        S_SLACK, S_SETUP, S_BOUND,
        S_CELL, S_CHK, S_SQRT, S_MUL, S_QH, S_WH, S_MRD, S_MWR,
        S_RADDR, S_RDATA, S_ROUT
    } state_t;

endpackage

`default_nettype wire

[sv/rism_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module rism_div (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              start,
    input  wire  [rism_pkg::DIV_N_W-1:0]     dividend,
    input  wire  [rism_pkg::DIV_D_W-1:0]     divisor,
    output logic                             done,
    output logic [rism_pkg::DIV_N_W-1:0]     quotient
);
    import rism_pkg::*;

    logic [DIV_N_W-1:0]   dvd_reg;
    logic [DIV_D_W-1:0]   dsr_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_D_W:0]     rem_sh;
    logic                 ge;

    // one restoring step: quotient bits shift in behind the dividend
    always_comb begin
        rem_sh = {rem_reg, dvd_reg[DIV_N_W-1]};
        ge     = rem_sh >= {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (run_reg) begin
            rem_reg <= ge ? DIV_D_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[DIV_D_W-1:0];
            dvd_reg <= {dvd_reg[DIV_N_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

[sv/radial_influence_splat_map.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Ports                     Content
// s_        in   tvalid/tready/tdata/tuser request: clear, splat or read
// m_        out  tvalid/tready/tdata       cell value of a read
// cfg_      in   wr_en/index/wdata         map and slack registers
//
// One request at a time. Clear: base value into all 16384 cells of the layer,
// one cell write each. Read: two 46-step passes of the shared divider.
// Splat: two such passes and setup, then per cell of the clipped square a
// distance check, and inside the disk an 18-step root, a divider pass, RMW.
// After reset a clearing pass over all 65536 words zeroes the store; no request
// is taken meanwhile. A waiting result stalls only the next read, at its output.

module radial_influence_splat_map (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // layer[1:0] pos_x[17:2] pos_z[33:18] threat_amount[57:34]
    // base_range[65:58] speed[81:66] unknown_source[82]
    input  wire  [87:0] s_tdata,
    // req_type[1:0]
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // cell_value[31:0]
    output logic [31:0] m_tdata,
    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_wdata
);
    import rism_pkg::*;

    // configuration
    logic [7:0]  map_width_reg, map_height_reg, slack_limit_reg;
    logic [10:0] cell_size_reg;
    logic [31:0] base_value_reg;
    logic [15:0] speed_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg   <= 8'd128;
            map_height_reg  <= 8'd128;
            cell_size_reg   <= 11'd64;
            base_value_reg  <= 32'd65536;
            speed_gain_reg  <= 16'd256;
            slack_limit_reg <= 8'd2;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WIDTH:  map_width_reg   <= cfg_wdata[7:0];
                CFG_HEIGHT: map_height_reg  <= cfg_wdata[7:0];
                CFG_CELL:   cell_size_reg   <= cfg_wdata[10:0];
                CFG_BASE:   base_value_reg  <= cfg_wdata;
                CFG_GAIN:   speed_gain_reg  <= cfg_wdata[15:0];
                CFG_SLACK:  slack_limit_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // effective map size and cell size
    logic [7:0]  w_eff, h_eff;
    logic [10:0] cs_eff;
    always_comb begin
        w_eff  = (map_width_reg == 8'd0) ? 8'd1 :
                 (map_width_reg > 8'(MAX_SIDE)) ? 8'(MAX_SIDE) : map_width_reg;
        h_eff  = (map_height_reg == 8'd0) ? 8'd1 :
                 (map_height_reg > 8'(MAX_SIDE)) ? 8'(MAX_SIDE) : map_height_reg;
        cs_eff = (cell_size_reg == 11'd0) ? 11'd1 : cell_size_reg;
    end

    state_t state_reg, state_next;
    logic   s_accept;
    assign s_accept = s_tvalid && s_tready;

    // request fields
    req_t        req_reg;
    logic [1:0]  layer_reg;
    logic [15:0] pos_x_reg, pos_z_reg, speed_reg;
    logic [23:0] threat_reg;
    logic [7:0]  brange_reg;
    logic        unknown_reg;

    // working registers
    logic [ADDR_W-1:0]        init_cnt_reg;
    logic [LAYER_CELLS_W-1:0] clr_cnt_reg;
    logic [15:0]  cx_reg, cz_reg, sl_reg;
    logic [8:0]   r_reg;
    logic [23:0]  thr_reg;
    logic [17:0]  r2_reg, full_reg;
    logic [7:0]   x0_reg, x1_reg, z1_reg, x_reg, z_reg;
    logic         empty_reg, inmap_reg;
    logic [20:0]  d2_reg;
    logic [34:0]  sq_v_reg, sq_res_reg, sq_bit_reg;
    logic [DIV_N_W-1:0] prod_reg;
    logic [27:0]  heat_reg;
    logic [31:0]  res_reg;
    logic         m_tvalid_reg;
    logic [31:0]  m_tdata_reg;

    // memory and divider hookup
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_addr;
    logic [DATA_W-1:0]   mem_wdata, mem_rdata_reg;
    logic [DATA_W-1:0]   store [2**ADDR_W];
    logic                div_start, div_done;
    logic [DIV_N_W-1:0]  div_dividend, div_quotient;
    logic [DIV_D_W-1:0]  div_divisor;

    rism_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // combinational helpers
    logic [7:0]  slack;
    logic [8:0]  r_calc;
    logic signed [17:0] x0_s, z0_s;
    logic [16:0] x1_u, z1_u;
    logic [7:0]  x1_c, z1_c;
    logic signed [9:0]  dx_s, dz_s;
    logic signed [19:0] dx_w, dz_w, dx2, dz2;
    logic [34:0] sq_sum;
    logic [17:0] sq_diff;
    logic [32:0] rmw_sum;
    logic        last_x, last_z;
    logic [7:0]  x_inc, z_inc;

    always_comb begin
        slack  = unknown_reg ? 8'd0 :
                 (sl_reg > {8'd0, slack_limit_reg}) ? slack_limit_reg : sl_reg[7:0];
        r_calc = {1'b0, brange_reg} + {1'b0, slack};
        x0_s   = $signed({2'b00, cx_reg}) - $signed({9'd0, r_reg}) + 18'sd1;
        z0_s   = $signed({2'b00, cz_reg}) - $signed({9'd0, r_reg}) + 18'sd1;
        x1_u   = {1'b0, cx_reg} + {8'd0, r_reg};
        z1_u   = {1'b0, cz_reg} + {8'd0, r_reg};
        x1_c   = (x1_u > {9'd0, w_eff}) ? w_eff : x1_u[7:0];
        z1_c   = (z1_u > {9'd0, h_eff}) ? h_eff : z1_u[7:0];
        // |cx-x| stays within the radius, 10 bits signed is enough
        dx_s   = 10'(cx_reg - {8'd0, x_reg});
        dz_s   = 10'(cz_reg - {8'd0, z_reg});
        dx_w   = 20'(dx_s);
        dz_w   = 20'(dz_s);
        dx2    = dx_w * dx_w;
        dz2    = dz_w * dz_w;
        sq_sum = sq_res_reg + sq_bit_reg;
        sq_diff = full_reg - sq_res_reg[17:0];
        rmw_sum = {1'b0, mem_rdata_reg} + {5'd0, heat_reg};
        x_inc  = x_reg + 8'd1;
        z_inc  = z_reg + 8'd1;
        last_x = x_inc == x1_reg;
        last_z = z_inc == z1_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:  if (init_cnt_reg == '1) state_next = S_IDLE;
            S_IDLE: begin
                if (s_accept) begin
                    case (req_t'(s_tuser))
                        REQ_CLEAR: state_next = S_CLR;
                        REQ_SPLAT: state_next = S_QX;
                        REQ_READ:  state_next = S_QX;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_CLR:   if (clr_cnt_reg == '1) state_next = S_IDLE;
            S_QX:    state_next = S_WX;
            S_WX:    if (div_done) state_next = S_QZ;
            S_QZ:    state_next = S_WZ;
            S_WZ:    if (div_done) state_next = (req_reg == REQ_READ) ? S_RADDR : S_SLACK;
            S_SLACK: state_next = S_SETUP;
            S_SETUP: state_next = S_BOUND;
            S_BOUND: state_next = S_CELL;
            S_CELL:  state_next = empty_reg ? S_IDLE : S_CHK;
            S_CHK: begin
                if (d2_reg <= {3'd0, r2_reg}) state_next = S_SQRT;
                else if (last_x && last_z) state_next = S_IDLE;
                else state_next = S_CELL;
            end
            S_SQRT:  if (sq_bit_reg[0]) state_next = S_MUL;
            S_MUL:   state_next = S_QH;
            S_QH:    state_next = S_WH;
            S_WH:    if (div_done) state_next = S_MRD;
            S_MRD:   state_next = S_MWR;
            S_MWR:   state_next = (last_x && last_z) ? S_IDLE : S_CELL;
            S_RADDR: state_next = S_RDATA;
            S_RDATA: state_next = S_ROUT;
            S_ROUT:  if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the state machine: memory port, divider, ready
    always_comb begin
        s_tready     = 1'b0;
        mem_we       = 1'b0;
        mem_addr     = {layer_reg, z_reg[SIDE_W-1:0], x_reg[SIDE_W-1:0]};
        mem_wdata    = rmw_sum[32] ? 32'hFFFF_FFFF : rmw_sum[31:0];
        div_start    = 1'b0;
        div_dividend = prod_reg;
        div_divisor  = full_reg;
        case (state_reg)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_addr  = init_cnt_reg;
                mem_wdata = '0;
            end
            S_IDLE:  s_tready = 1'b1;
            S_CLR: begin
                mem_we    = 1'b1;
                mem_addr  = {layer_reg, clr_cnt_reg};
                mem_wdata = base_value_reg;
            end
            S_QX: begin
                div_start    = 1'b1;
                div_dividend = DIV_N_W'(pos_x_reg);
                div_divisor  = DIV_D_W'(cs_eff);
            end
            S_QZ: begin
                div_start    = 1'b1;
                div_dividend = DIV_N_W'(pos_z_reg);
                div_divisor  = DIV_D_W'(cs_eff);
            end
            S_QH:    div_start = 1'b1;
            S_MWR:   mem_we = 1'b1;
            S_RADDR: mem_addr = {layer_reg, cz_reg[SIDE_W-1:0], cx_reg[SIDE_W-1:0]};
            default: ;
        endcase
    end

    // store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) store[mem_addr] <= mem_wdata;
        mem_rdata_reg <= store[mem_addr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            init_cnt_reg <= '0;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_INIT) init_cnt_reg <= init_cnt_reg + 1'b1;
            if (state_reg == S_CLR) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            else clr_cnt_reg <= '0;
            if (state_reg == S_ROUT && (!m_tvalid_reg || m_tready)) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg     <= req_t'(s_tuser);
            layer_reg   <= s_tdata[1:0];
            pos_x_reg   <= s_tdata[17:2];
            pos_z_reg   <= s_tdata[33:18];
            threat_reg  <= s_tdata[57:34];
            brange_reg  <= s_tdata[65:58];
            speed_reg   <= s_tdata[81:66];
            unknown_reg <= s_tdata[82];
        end
        if (state_reg == S_ROUT && (!m_tvalid_reg || m_tready)) m_tdata_reg <= res_reg;
        case (state_reg)
            S_WX: if (div_done) cx_reg <= div_quotient[15:0];
            S_WZ: if (div_done) cz_reg <= div_quotient[15:0];
            S_SLACK: sl_reg <= 16'((32'(speed_reg) * 32'(speed_gain_reg)) >> 16);
            S_SETUP: begin
                r_reg   <= r_calc;
                thr_reg <= unknown_reg ? UNKNOWN_THREAT : threat_reg;
            end
            S_BOUND: begin
                r2_reg    <= 18'(r_reg * r_reg);
                full_reg  <= {r_reg, 9'd0};
                x0_reg    <= (x0_s < 18'sd0) ? 8'd0 : x0_s[7:0];
                x_reg     <= (x0_s < 18'sd0) ? 8'd0 : x0_s[7:0];
                z_reg     <= (z0_s < 18'sd0) ? 8'd0 : z0_s[7:0];
                x1_reg    <= x1_c;
                z1_reg    <= z1_c;
                empty_reg <= (x0_s >= $signed({10'd0, x1_c})) ||
                             (z0_s >= $signed({10'd0, z1_c}));
            end
            S_CELL: d2_reg <= 21'($unsigned(dx2)) + 21'($unsigned(dz2));
            S_CHK: begin
                sq_v_reg   <= {d2_reg[17:0], 16'd0};
                sq_res_reg <= '0;
                sq_bit_reg <= 35'd1 << 34;
                if (d2_reg > {3'd0, r2_reg}) begin
                    x_reg <= last_x ? x0_reg : x_inc;
                    if (last_x) z_reg <= z_inc;
                end
            end
            S_SQRT: begin
                if (sq_v_reg >= sq_sum) begin
                    sq_v_reg   <= sq_v_reg - sq_sum;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            S_MUL: prod_reg <= DIV_N_W'({thr_reg, 4'd0}) * DIV_N_W'(sq_diff);
            S_WH:  if (div_done) heat_reg <= div_quotient[27:0];
            S_MWR: begin
                x_reg <= last_x ? x0_reg : x_inc;
                if (last_x) z_reg <= z_inc;
            end
            S_RADDR: inmap_reg <= (cx_reg < {8'd0, w_eff}) && (cz_reg < {8'd0, h_eff});
            S_RDATA: res_reg <= (inmap_reg && mem_rdata_reg > base_value_reg) ?
                                mem_rdata_reg - base_value_reg : 32'd0;
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_WX || state_reg == S_WZ || state_reg == S_WH))
        else $error("divider finished outside a wait state");
    a_rmw_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MWR) |-> $past(state_reg == S_MRD))
        else $error("cell write without preceding read");
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_ROUT))
        else $error("result raised outside read completion");
`endif

endmodule

`default_nettype wire
